@@ sv/prrs_pkg.sv @@
// ----------------------------------------------------------------------------
// prrs_pkg: shared types and constants of the thread scheduler
// Holds the event codes, the result codes, the idle thread values and the
// command/status types between the controller and the datapath.
// ----------------------------------------------------------------------------
package prrs_pkg;

    // event codes of the input request
    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_YIELD   = 3'd1;
    localparam logic [2:0] KIND_ADD     = 3'd2;
    localparam logic [2:0] KIND_KILL    = 3'd3;
    localparam logic [2:0] KIND_SLEEP   = 3'd4;
    localparam logic [2:0] KIND_BLOCK   = 3'd5;
    localparam logic [2:0] KIND_UNBLOCK = 3'd6;

    // result codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_FULL     = 2'd1;
    localparam logic [1:0] STS_BAD_ID   = 2'd2;
    localparam logic [1:0] STS_NOTFOUND = 2'd3;

    localparam logic [15:0] IDLE_ID   = 16'hFFFF;
    localparam logic [7:0]  IDLE_PRIO = 8'hFF;

    typedef logic [4:0] t_cmd;

    localparam t_cmd CMD_NONE         = 5'd0;
    localparam t_cmd CMD_INIT         = 5'd1;
    localparam t_cmd CMD_LOAD         = 5'd2;
    localparam t_cmd CMD_TICK         = 5'd3;
    localparam t_cmd CMD_SLEEP        = 5'd4;
    localparam t_cmd CMD_SCH_START    = 5'd5;
    localparam t_cmd CMD_PASS1        = 5'd6;
    localparam t_cmd CMD_P2_START     = 5'd7;
    localparam t_cmd CMD_PASS2        = 5'd8;
    localparam t_cmd CMD_SET_FULL     = 5'd9;
    localparam t_cmd CMD_SET_BADID    = 5'd10;
    localparam t_cmd CMD_SET_NOTFOUND = 5'd11;
    localparam t_cmd CMD_SCAN_START   = 5'd12;
    localparam t_cmd CMD_SCAN         = 5'd13;
    localparam t_cmd CMD_ADD_W1       = 5'd14;
    localparam t_cmd CMD_ADD_W2       = 5'd15;
    localparam t_cmd CMD_FIND_START   = 5'd16;
    localparam t_cmd CMD_FIND         = 5'd17;
    localparam t_cmd CMD_KILL         = 5'd18;
    localparam t_cmd CMD_BLOCK        = 5'd19;
    localparam t_cmd CMD_UNBLOCK      = 5'd20;
    localparam t_cmd CMD_OUT_LOAD     = 5'd21;

    typedef struct packed {
        logic       hit;        // walked slot runnable at the top priority
        logic       last_live;  // walk has covered every live slot
        logic       last_slot;  // counter at the highest slot index
        logic       free;       // scanned slot is dead
        logic       match;      // walked slot holds the requested id
        logic       full;       // every slot is live
        logic       bad_id;     // requested id is the reserved one
        logic       sel_zero;   // found slot is the idle slot
        logic       sel_is_cur; // found slot is running
        logic       out_free;   // output register can take a result
        logic [2:0] kind;
    } t_sts;

endpackage

@@ sv/prrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// prrs_ctrl: sequencer of the thread scheduler
// Steps each request through its micro-operations and issues one datapath
// command per cycle.
// ----------------------------------------------------------------------------
module prrs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  prrs_pkg::t_sts   i_sts,
    output prrs_pkg::t_cmd   o_cmd
);

    localparam logic [4:0] ST_INIT     = 5'd0;
    localparam logic [4:0] ST_IDLE     = 5'd1;
    localparam logic [4:0] ST_DISPATCH = 5'd2;
    localparam logic [4:0] ST_TICK     = 5'd3;
    localparam logic [4:0] ST_SLEEP    = 5'd4;
    localparam logic [4:0] ST_SCH0     = 5'd5;
    localparam logic [4:0] ST_SCH1     = 5'd6;
    localparam logic [4:0] ST_P1       = 5'd7;
    localparam logic [4:0] ST_P2S      = 5'd8;
    localparam logic [4:0] ST_P2       = 5'd9;
    localparam logic [4:0] ST_ADD0     = 5'd10;
    localparam logic [4:0] ST_ADD1     = 5'd11;
    localparam logic [4:0] ST_ADD2     = 5'd12;
    localparam logic [4:0] ST_ADD3     = 5'd13;
    localparam logic [4:0] ST_ADD4     = 5'd14;
    localparam logic [4:0] ST_FIND0    = 5'd15;
    localparam logic [4:0] ST_FIND1    = 5'd16;
    localparam logic [4:0] ST_FOUND    = 5'd17;
    localparam logic [4:0] ST_OUT_RD   = 5'd18;
    localparam logic [4:0] ST_OUT      = 5'd19;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = prrs_pkg::CMD_NONE;
        o_stall = 1'b1;
        unique case (r_state)
            ST_INIT: begin
                o_cmd   = prrs_pkg::CMD_INIT;
                n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd   = prrs_pkg::CMD_LOAD;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (i_sts.kind)
                    prrs_pkg::KIND_TICK:    n_state = ST_TICK;
                    prrs_pkg::KIND_YIELD:   n_state = ST_SCH0;
                    prrs_pkg::KIND_ADD:     n_state = ST_ADD0;
                    prrs_pkg::KIND_KILL:    n_state = ST_FIND0;
                    prrs_pkg::KIND_SLEEP:   n_state = ST_SLEEP;
                    prrs_pkg::KIND_BLOCK:   n_state = ST_FIND0;
                    prrs_pkg::KIND_UNBLOCK: n_state = ST_FIND0;
                    default:                n_state = ST_OUT_RD;
                endcase
            end
            ST_TICK: begin
                o_cmd   = prrs_pkg::CMD_TICK;
                n_state = ST_SCH0;
            end
            ST_SLEEP: begin
                o_cmd   = prrs_pkg::CMD_SLEEP;
                n_state = ST_SCH0;
            end
            ST_SCH0: n_state = ST_SCH1;
            ST_SCH1: begin
                o_cmd   = prrs_pkg::CMD_SCH_START;
                n_state = ST_P1;
            end
            ST_P1: begin
                o_cmd = prrs_pkg::CMD_PASS1;
                if (i_sts.last_live) n_state = ST_P2S;
            end
            ST_P2S: begin
                o_cmd   = prrs_pkg::CMD_P2_START;
                n_state = ST_P2;
            end
            ST_P2: begin
                o_cmd = prrs_pkg::CMD_PASS2;
                if (i_sts.hit || i_sts.last_slot) n_state = ST_OUT_RD;
            end
            ST_ADD0: begin
                priority if (i_sts.full) begin
                    o_cmd   = prrs_pkg::CMD_SET_FULL;
                    n_state = ST_OUT_RD;
                end else if (i_sts.bad_id) begin
                    o_cmd   = prrs_pkg::CMD_SET_BADID;
                    n_state = ST_OUT_RD;
                end else begin
                    o_cmd   = prrs_pkg::CMD_SCAN_START;
                    n_state = ST_ADD1;
                end
            end
            ST_ADD1: begin
                o_cmd = prrs_pkg::CMD_SCAN;
                priority if (i_sts.free) n_state = ST_ADD2;
                else if (i_sts.last_slot) n_state = ST_OUT_RD;
                else n_state = ST_ADD1;
            end
            ST_ADD2: n_state = ST_ADD3;
            ST_ADD3: begin
                o_cmd   = prrs_pkg::CMD_ADD_W1;
                n_state = ST_ADD4;
            end
            ST_ADD4: begin
                o_cmd   = prrs_pkg::CMD_ADD_W2;
                n_state = ST_OUT_RD;
            end
            ST_FIND0: begin
                if (i_sts.bad_id) begin
                    o_cmd   = prrs_pkg::CMD_SET_BADID;
                    n_state = ST_OUT_RD;
                end else begin
                    o_cmd   = prrs_pkg::CMD_FIND_START;
                    n_state = ST_FIND1;
                end
            end
            ST_FIND1: begin
                o_cmd = prrs_pkg::CMD_FIND;
                priority if (i_sts.match) n_state = ST_FOUND;
                else if (i_sts.last_live) n_state = ST_OUT_RD;
                else n_state = ST_FIND1;
            end
            ST_FOUND: begin
                n_state = ST_OUT_RD;
                priority if (i_sts.sel_zero) begin
                    o_cmd = prrs_pkg::CMD_SET_NOTFOUND;
                end else if (i_sts.kind == prrs_pkg::KIND_KILL) begin
                    o_cmd = prrs_pkg::CMD_KILL;
                    if (i_sts.sel_is_cur) n_state = ST_SCH0;
                end else if (i_sts.kind == prrs_pkg::KIND_BLOCK) begin
                    o_cmd = prrs_pkg::CMD_BLOCK;
                    if (i_sts.sel_is_cur) n_state = ST_SCH0;
                end else begin
                    o_cmd = prrs_pkg::CMD_UNBLOCK;
                end
            end
            ST_OUT_RD: n_state = ST_OUT;
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd   = prrs_pkg::CMD_OUT_LOAD;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/prrs_dpath.sv @@
// ----------------------------------------------------------------------------
// prrs_dpath: slot storage and walk datapath of the thread scheduler
// Holds the slot flags, the ring link/priority/id/wake memories, the walk
// pointer and counter, and the output register.
// ----------------------------------------------------------------------------
module prrs_dpath #(
    parameter int THREAD_SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  prrs_pkg::t_cmd   i_cmd,
    output prrs_pkg::t_sts   o_sts,
    input  logic [2:0]       i_kind,
    input  logic [15:0]      i_thread_id,
    input  logic [7:0]       i_priority_req,
    input  logic [31:0]      i_duration,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [3:0]       o_running_slot,
    output logic [15:0]      o_running_id,
    output logic [1:0]       o_status
);

    localparam int SW = $clog2(THREAD_SLOTS);
    localparam int LW = $clog2(THREAD_SLOTS + 1);

    logic [2:0]        r_kind;
    logic [15:0]       r_id;
    logic [7:0]        r_prio;
    logic [31:0]       r_dur;
    logic [1:0]        r_status;
    logic [SW-1:0]     r_cur, r_walk, r_start, r_sel, r_sn, r_sp, r_nc, r_cnt;
    logic [7:0]        r_top;
    logic [31:0]       r_time;
    logic [LW-1:0]     r_live;
    logic [THREAD_SLOTS-1:0] r_alive, r_blocked, r_asleep;

    logic              r_out_valid;
    logic [3:0]        r_out_slot;
    logic [15:0]       r_out_id;
    logic [1:0]        r_out_status;

    logic [SW-1:0]     r_next_mem  [THREAD_SLOTS];
    logic [SW-1:0]     r_prev_mem  [THREAD_SLOTS];
    logic [7:0]        r_prio_mem  [THREAD_SLOTS];
    logic [15:0]       r_ident_mem [THREAD_SLOTS];
    logic [31:0]       r_wake_mem  [THREAD_SLOTS];

    logic [SW-1:0]     r_q_next, r_q_prev;
    logic [7:0]        r_q_prio;
    logic [15:0]       r_q_ident;
    logic [31:0]       r_q_wake;

    logic [SW-1:0]     w_raddr;
    logic              w_next_we, w_prev_we, w_rec_we, w_wake_we;
    logic [SW-1:0]     w_next_wa, w_next_wd, w_prev_wa, w_prev_wd, w_rec_wa, w_wake_wa;
    logic [7:0]        w_prio_wd;
    logic [15:0]       w_ident_wd;
    logic [31:0]       w_wake_wd;

    logic w_ready_base, w_run, w_due_wake, w_hit, w_match;
    logic w_last_live, w_last_slot, w_free;

    // runnable test on the slot whose record sits in the read registers
    assign w_ready_base = r_alive[r_walk] && !r_blocked[r_walk];
    assign w_run        = w_ready_base && (!r_asleep[r_walk] || !(r_q_wake > r_time));
    assign w_due_wake   = w_ready_base && r_asleep[r_walk] && !(r_q_wake > r_time);
    assign w_hit        = w_run && (r_q_prio == r_top);
    assign w_match      = r_alive[r_walk] && (r_q_ident == r_id);
    assign w_last_live  = (LW'(r_cnt) == (r_live - LW'(1)));
    assign w_last_slot  = (r_cnt == SW'(THREAD_SLOTS - 1));
    assign w_free       = !r_alive[r_cnt];

    always_comb begin
        o_sts.hit        = w_hit;
        o_sts.last_live  = w_last_live;
        o_sts.last_slot  = w_last_slot;
        o_sts.free       = w_free;
        o_sts.match      = w_match;
        o_sts.full       = (r_live == LW'(THREAD_SLOTS));
        o_sts.bad_id     = (r_id == prrs_pkg::IDLE_ID);
        o_sts.sel_zero   = (r_sel == '0);
        o_sts.sel_is_cur = (r_sel == r_cur);
        o_sts.out_free   = !r_out_valid || !i_out_stall;
        o_sts.kind       = r_kind;
    end

    // read address: follow the link while walking, the walk start at pass-two start, else the running slot
    always_comb begin
        unique case (i_cmd)
            prrs_pkg::CMD_SCH_START,
            prrs_pkg::CMD_PASS1,
            prrs_pkg::CMD_PASS2,
            prrs_pkg::CMD_FIND:     w_raddr = r_q_next;
            prrs_pkg::CMD_P2_START: w_raddr = r_start;
            default:                w_raddr = r_cur;
        endcase
    end

    always_comb begin
        w_next_we  = 1'b0;
        w_next_wa  = r_cur;
        w_next_wd  = r_sel;
        w_prev_we  = 1'b0;
        w_prev_wa  = r_nc;
        w_prev_wd  = r_sel;
        w_rec_we   = 1'b0;
        w_rec_wa   = r_sel;
        w_prio_wd  = r_prio;
        w_ident_wd = r_id;
        w_wake_we  = 1'b0;
        w_wake_wa  = r_sel;
        w_wake_wd  = '0;
        unique case (i_cmd)
            prrs_pkg::CMD_INIT: begin
                w_next_we  = 1'b1;
                w_next_wa  = '0;
                w_next_wd  = '0;
                w_prev_we  = 1'b1;
                w_prev_wa  = '0;
                w_prev_wd  = '0;
                w_rec_we   = 1'b1;
                w_rec_wa   = '0;
                w_prio_wd  = prrs_pkg::IDLE_PRIO;
                w_ident_wd = prrs_pkg::IDLE_ID;
            end
            prrs_pkg::CMD_ADD_W1: begin
                // new record, linked between the running slot and its successor
                w_next_we = 1'b1;
                w_next_wa = r_sel;
                w_next_wd = r_q_next;
                w_prev_we = 1'b1;
                w_prev_wa = r_sel;
                w_prev_wd = r_cur;
                w_rec_we  = 1'b1;
                w_wake_we = 1'b1;
            end
            prrs_pkg::CMD_ADD_W2: begin
                w_next_we = 1'b1;
                w_prev_we = 1'b1;
            end
            prrs_pkg::CMD_KILL: begin
                w_next_we = 1'b1;
                w_next_wa = r_sp;
                w_next_wd = r_sn;
                w_prev_we = 1'b1;
                w_prev_wa = r_sn;
                w_prev_wd = r_sp;
            end
            prrs_pkg::CMD_SLEEP: begin
                w_wake_we = (r_cur != '0);
                w_wake_wa = r_cur;
                w_wake_wd = r_time + r_dur;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_next_we) r_next_mem[w_next_wa] <= w_next_wd;
        if (w_prev_we) r_prev_mem[w_prev_wa] <= w_prev_wd;
        if (w_rec_we) begin
            r_prio_mem[w_rec_wa]  <= w_prio_wd;
            r_ident_mem[w_rec_wa] <= w_ident_wd;
        end
        if (w_wake_we) r_wake_mem[w_wake_wa] <= w_wake_wd;
        r_q_next  <= r_next_mem[w_raddr];
        r_q_prev  <= r_prev_mem[w_raddr];
        r_q_prio  <= r_prio_mem[w_raddr];
        r_q_ident <= r_ident_mem[w_raddr];
        r_q_wake  <= r_wake_mem[w_raddr];
    end

    // output valid: set on load, drop once the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == prrs_pkg::CMD_OUT_LOAD) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_time      <= '0;
            r_live      <= LW'(1);
            r_alive     <= THREAD_SLOTS'(1);
            r_blocked   <= '0;
            r_asleep    <= '0;
        end else begin
            unique case (i_cmd)
                prrs_pkg::CMD_LOAD: begin
                    r_kind   <= i_kind;
                    r_id     <= i_thread_id;
                    r_prio   <= i_priority_req;
                    r_dur    <= i_duration;
                    r_status <= prrs_pkg::STS_OK;
                end
                prrs_pkg::CMD_TICK: r_time <= r_time + 32'd1;
                prrs_pkg::CMD_SLEEP: begin
                    if (r_cur != '0) r_asleep[r_cur] <= 1'b1;
                end
                prrs_pkg::CMD_SCH_START: begin
                    r_walk  <= r_q_next;
                    r_start <= r_q_next;
                    r_cnt   <= '0;
                    r_top   <= prrs_pkg::IDLE_PRIO;
                end
                prrs_pkg::CMD_PASS1: begin
                    if (w_due_wake) r_asleep[r_walk] <= 1'b0;
                    if (w_run && (r_q_prio < r_top)) r_top <= r_q_prio;
                    r_walk <= r_q_next;
                    r_cnt  <= r_cnt + SW'(1);
                end
                prrs_pkg::CMD_P2_START: begin
                    r_walk <= r_start;
                    r_cnt  <= '0;
                end
                prrs_pkg::CMD_PASS2: begin
                    if (w_due_wake) r_asleep[r_walk] <= 1'b0;
                    if (w_hit) begin
                        r_cur <= r_walk;
                    end else begin
                        r_walk <= r_q_next;
                        r_cnt  <= r_cnt + SW'(1);
                    end
                end
                prrs_pkg::CMD_SET_FULL:     r_status <= prrs_pkg::STS_FULL;
                prrs_pkg::CMD_SET_BADID:    r_status <= prrs_pkg::STS_BAD_ID;
                prrs_pkg::CMD_SET_NOTFOUND: r_status <= prrs_pkg::STS_NOTFOUND;
                prrs_pkg::CMD_SCAN_START:   r_cnt <= SW'(1);
                prrs_pkg::CMD_SCAN: begin
                    if (w_free) begin
                        r_sel <= r_cnt;
                    end else begin
                        r_cnt <= r_cnt + SW'(1);
                        if (w_last_slot) r_status <= prrs_pkg::STS_FULL;
                    end
                end
                prrs_pkg::CMD_ADD_W1: r_nc <= r_q_next;
                prrs_pkg::CMD_ADD_W2: begin
                    r_alive[r_sel]   <= 1'b1;
                    r_blocked[r_sel] <= 1'b0;
                    r_asleep[r_sel]  <= 1'b0;
                    r_live           <= r_live + LW'(1);
                end
                prrs_pkg::CMD_FIND_START: begin
                    r_walk <= r_cur;
                    r_cnt  <= '0;
                end
                prrs_pkg::CMD_FIND: begin
                    if (w_match) begin
                        r_sel <= r_walk;
                        r_sn  <= r_q_next;
                        r_sp  <= r_q_prev;
                    end else begin
                        r_walk <= r_q_next;
                        r_cnt  <= r_cnt + SW'(1);
                        if (w_last_live) r_status <= prrs_pkg::STS_NOTFOUND;
                    end
                end
                prrs_pkg::CMD_KILL: begin
                    r_alive[r_sel] <= 1'b0;
                    if (r_live > LW'(1)) r_live <= r_live - LW'(1);
                end
                prrs_pkg::CMD_BLOCK:   r_blocked[r_sel] <= 1'b1;
                prrs_pkg::CMD_UNBLOCK: r_blocked[r_sel] <= 1'b0;
                prrs_pkg::CMD_OUT_LOAD: begin
                    r_out_slot   <= 4'(r_cur);
                    r_out_id     <= r_q_ident;
                    r_out_status <= r_status;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_running_slot = r_out_slot;
    assign o_running_id   = r_out_id;
    assign o_status       = r_out_status;

    a_live_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_alive) == int'(r_live))
        else $error("live count differs from live slots");

    a_idle_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alive[0] && !r_blocked[0] && !r_asleep[0])
        else $error("idle slot lost its state");

    a_result_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == prrs_pkg::CMD_OUT_LOAD) |-> r_alive[r_cur])
        else $error("chosen slot is not live");

endmodule

@@ sv/priority_round_robin_thread_scheduler.sv @@
// ----------------------------------------------------------------------------
// priority_round_robin_thread_scheduler: priority round-robin thread scheduler
// Ring of thread slots with tick, yield, add, kill, sleep, block and unblock
// requests; each request returns the running thread and a status code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_stall carries one request (kind, thread id,
//   priority, duration). Output channel o_valid/i_stall returns one result
//   per request: running slot, running id and status.
//   One request is in work at a time. Steps of each request, with L live threads:
//     schedule (tick, yield, sleep):  pass one walks the L live slots for the top
//                                     priority, pass two walks on to the first
//                                     runnable slot at that priority
//     add:                            dead-slot scan over the slots above slot 0
//     kill/block/unblock:             walk for the id, plus a schedule when the
//                                     running thread is hit
//   The walk over the ring reads one slot record per cycle from the slot memories.
//   Reset: one cycle after reset goes to writing the idle thread (slot 0,
//   id 65535, priority 255) into the memories; o_stall is high until then.
//   Receiver stall: the result is held in an output register; the block
//   accepts the next request meanwhile and holds its own result until the
//   register is taken.
// ----------------------------------------------------------------------------
module priority_round_robin_thread_scheduler #(
    parameter int THREAD_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_thread_id,
    input  logic [7:0]  i_priority_req,
    input  logic [31:0] i_duration,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_running_slot,
    output logic [15:0] o_running_id,
    output logic [1:0]  o_status
);

    prrs_pkg::t_cmd w_cmd;
    prrs_pkg::t_sts w_sts;

    // sequencer: one command per cycle
    prrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // slot storage, ring walk and output register
    prrs_dpath #(
        .THREAD_SLOTS (THREAD_SLOTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_kind         (i_kind),
        .i_thread_id    (i_thread_id),
        .i_priority_req (i_priority_req),
        .i_duration     (i_duration),
        .i_out_stall    (i_stall),
        .o_out_valid    (o_valid),
        .o_running_slot (o_running_slot),
        .o_running_id   (o_running_id),
        .o_status       (o_status)
    );

endmodule

@@ tb/tb_priority_round_robin_thread_scheduler.sv @@
// ----------------------------------------------------------------------------
// tb_priority_round_robin_thread_scheduler: self-checking bench of the scheduler
// Drives a directed table of requests, then random thread-lifecycle traffic
// under several idle/stall phases; every result is checked against typed table
// values or an in-bench scheduler model that keeps its own ring, flags and clock.
// ----------------------------------------------------------------------------
module tb_priority_round_robin_thread_scheduler;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    // kind code with no meaning, ignored by the block
    localparam logic [2:0] KIND_SPARE = 3'd7;

    typedef struct {
        logic [2:0]  kind;
        logic [15:0] tid;
        logic [7:0]  prio;
        logic [31:0] dur;
    } t_req;

    typedef struct {
        logic [3:0]  slot;
        logic [15:0] id;
        logic [1:0]  sts;
        bit          typed;   // expected values typed into the table row
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [2:0]  i_kind = '0;
    logic [15:0] i_thread_id = '0;
    logic [7:0]  i_priority_req = '0;
    logic [31:0] i_duration = '0;
    logic        i_stall = 1'b0;
    logic        o_stall, o_valid;
    logic [3:0]  o_running_slot;
    logic [15:0] o_running_id;
    logic [1:0]  o_status;

    priority_round_robin_thread_scheduler #(.THREAD_SLOTS(SLOTS)) DUT (.*);

    always #5 i_clk = ~i_clk;

    // scheduler model state
    bit          alive[SLOTS], blocked[SLOTS], asleep[SLOTS];
    logic [7:0]  prio_q[SLOTS];
    logic [15:0] ident[SLOTS];
    logic [31:0] wake_at[SLOTS];
    logic [3:0]  nxt[SLOTS], prv[SLOTS];
    logic [3:0]  cur_slot;
    logic [31:0] sys_time;
    int          live;

    t_res        pending_results[$];
    int          errors = 0;
    int          send_idle_pct = 0, recv_stall_pct = 0;

    function automatic bit ready_to_run(int s);
        if (!alive[s] || blocked[s]) return 0;
        if (asleep[s]) begin
            if (wake_at[s] > sys_time) return 0;
            asleep[s] = 0;
        end
        return 1;
    endfunction

    function automatic void pick_next();
        int s;
        int top;
        s = nxt[cur_slot];
        top = prrs_pkg::IDLE_PRIO;
        for (int i = 0; i < live && i < SLOTS; i++) begin
            if (ready_to_run(s) && prio_q[s] < top) top = prio_q[s];
            s = nxt[s];
        end
        s = nxt[cur_slot];
        for (int i = 0; i < SLOTS; i++) begin
            if (ready_to_run(s) && prio_q[s] == top) begin
                cur_slot = 4'(s);
                return;
            end
            s = nxt[s];
        end
    endfunction

    function automatic int find_thread(logic [15:0] id);
        int s;
        s = cur_slot;
        for (int i = 0; i < live && i < SLOTS; i++) begin
            if (alive[s] && ident[s] == id) return s;
            s = nxt[s];
        end
        return SLOTS;
    endfunction

    function automatic void sched_reset();
        for (int i = 0; i < SLOTS; i++) begin
            alive[i] = 0; blocked[i] = 0; asleep[i] = 0;
            prio_q[i] = 0; ident[i] = 0; wake_at[i] = 0; nxt[i] = 0; prv[i] = 0;
        end
        alive[0] = 1; prio_q[0] = prrs_pkg::IDLE_PRIO; ident[0] = prrs_pkg::IDLE_ID;
        cur_slot = 0; sys_time = 0; live = 1;
    endfunction

    function automatic t_res sched_apply(t_req r);
        t_res o;
        logic [1:0] sts;
        int s;
        int c;
        sts = prrs_pkg::STS_OK;
        c = cur_slot;
        case (r.kind)
            prrs_pkg::KIND_TICK: begin
                sys_time = sys_time + 32'd1;
                pick_next();
            end
            prrs_pkg::KIND_YIELD: pick_next();
            prrs_pkg::KIND_ADD: begin
                s = SLOTS;
                if (live >= SLOTS) sts = prrs_pkg::STS_FULL;
                else if (r.tid == prrs_pkg::IDLE_ID) sts = prrs_pkg::STS_BAD_ID;
                else begin
                    for (int i = 1; i < SLOTS; i++)
                        if (!alive[i]) begin s = i; break; end
                    if (s >= SLOTS) sts = prrs_pkg::STS_FULL;
                end
                if (sts == prrs_pkg::STS_OK) begin
                    alive[s] = 1; blocked[s] = 0; asleep[s] = 0; wake_at[s] = 0;
                    prio_q[s] = r.prio; ident[s] = r.tid;
                    nxt[s] = nxt[c]; prv[s] = 4'(c);
                    prv[nxt[c]] = 4'(s); nxt[c] = 4'(s);
                    live++;
                end
            end
            prrs_pkg::KIND_KILL, prrs_pkg::KIND_BLOCK, prrs_pkg::KIND_UNBLOCK: begin
                s = SLOTS;
                if (r.tid == prrs_pkg::IDLE_ID) sts = prrs_pkg::STS_BAD_ID;
                else begin
                    s = find_thread(r.tid);
                    if (s >= SLOTS || s == 0) sts = prrs_pkg::STS_NOTFOUND;
                end
                if (sts == prrs_pkg::STS_OK) begin
                    if (r.kind == prrs_pkg::KIND_KILL) begin
                        alive[s] = 0;
                        nxt[prv[s]] = nxt[s];
                        prv[nxt[s]] = prv[s];
                        if (live > 1) live--;
                        if (s == c) pick_next();
                    end else if (r.kind == prrs_pkg::KIND_BLOCK) begin
                        blocked[s] = 1;
                        if (s == c) pick_next();
                    end else begin
                        blocked[s] = 0;
                    end
                end
            end
            prrs_pkg::KIND_SLEEP: begin
                if (c != 0) begin
                    asleep[c] = 1;
                    wake_at[c] = sys_time + r.dur;
                end
                pick_next();
            end
            default: ;
        endcase
        o.slot = cur_slot; o.id = ident[cur_slot]; o.sts = sts; o.typed = 0;
        return o;
    endfunction

    // push one request through the input handshake; predict at acceptance
    task automatic send_request(t_req r, bit typed = 0, logic [3:0] e_slot = '0,
                                logic [15:0] e_id = '0, logic [1:0] e_sts = '0);
        t_res p;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= r.kind; i_thread_id <= r.tid;
        i_priority_req <= r.prio; i_duration <= r.dur;
        do @(posedge i_clk); while (o_stall);
        p = sched_apply(r);
        if (typed) begin
            // table value takes precedence; a disagreeing model is only displayed, not counted as an error
            p.typed = 1;
            if (p.slot != e_slot || p.id != e_id || p.sts != e_sts)
                $display("%0t: table row disagrees with model: slot %0d id %0d sts %0d",
                         $time, e_slot, e_id, e_sts);
            p.slot = e_slot; p.id = e_id; p.sts = e_sts;
        end
        pending_results.push_back(p);
    endtask

    task automatic go_quiet();
        i_valid <= 1'b0;
    endtask

    // receiver: random stalls, check at acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result slot %0d id %0d status %0d",
                         $time, o_running_slot, o_running_id, o_status);
                errors++;
            end else begin
                t_res e;
                e = pending_results.pop_front();
                if (o_running_slot !== e.slot) begin
                    $display("%0t: running_slot expected %0d actual %0d",
                             $time, e.slot, o_running_slot);
                    errors++;
                end
                if (o_running_id !== e.id) begin
                    $display("%0t: running_id expected %0d actual %0d",
                             $time, e.id, o_running_id);
                    errors++;
                end
                if (o_status !== e.sts) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, e.sts, o_status);
                    errors++;
                end
            end
        end
        i_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // pick an id that is live most of the time, so kill/block hit real threads
    function automatic logic [15:0] some_id();
        int s;
        if ($urandom_range(99) < 75) begin
            s = $urandom_range(SLOTS - 1);
            if (alive[s] && s != 0) return ident[s];
        end
        case ($urandom_range(3))
            0: return 16'($urandom_range(15));
            1: return prrs_pkg::IDLE_ID;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_req random_request();
        t_req r;
        int pick;
        pick = $urandom_range(99);
        r.tid = some_id();
        r.prio = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(4));
        r.dur = ($urandom_range(7) == 0) ? $urandom : $urandom_range(5);
        if (pick < 25) r.kind = prrs_pkg::KIND_TICK;
        else if (pick < 33) r.kind = prrs_pkg::KIND_YIELD;
        else if (pick < 53) begin
            r.kind = prrs_pkg::KIND_ADD;
            if ($urandom_range(3) != 0) r.tid = 16'($urandom_range(15));
        end
        else if (pick < 63) r.kind = prrs_pkg::KIND_KILL;
        else if (pick < 73) r.kind = prrs_pkg::KIND_SLEEP;
        else if (pick < 84) r.kind = prrs_pkg::KIND_BLOCK;
        else if (pick < 98) r.kind = prrs_pkg::KIND_UNBLOCK;
        else r.kind = KIND_SPARE;
        return r;
    endfunction

    typedef struct {
        t_req        r;
        bit          typed;
        logic [3:0]  slot;
        logic [15:0] id;
        logic [1:0]  sts;
    } t_row;

    t_row directed_rows[$];

    function automatic void add_row(logic [2:0] k, logic [15:0] t, logic [7:0] p,
                                    logic [31:0] d, bit ty = 0, logic [3:0] es = 0,
                                    logic [15:0] ei = 0, logic [1:0] est = 0);
        t_row w;
        w.r.kind = k; w.r.tid = t; w.r.prio = p; w.r.dur = d;
        w.typed = ty; w.slot = es; w.id = ei; w.sts = est;
        directed_rows.push_back(w);
    endfunction

    initial begin
        int phase_pct[4][2];
        // after reset: idle thread runs; reserved and missing ids
        add_row(prrs_pkg::KIND_YIELD, 16'd0, 8'd0, 32'd0, 1, 4'd0,
                prrs_pkg::IDLE_ID, prrs_pkg::STS_OK);
        add_row(prrs_pkg::KIND_TICK, 16'd0, 8'd0, 32'd0, 1, 4'd0,
                prrs_pkg::IDLE_ID, prrs_pkg::STS_OK);
        add_row(prrs_pkg::KIND_SLEEP, 16'd0, 8'd0, 32'hFFFFFFFF, 1, 4'd0,
                prrs_pkg::IDLE_ID, prrs_pkg::STS_OK);
        add_row(prrs_pkg::KIND_KILL, prrs_pkg::IDLE_ID, 8'd0, 32'd0, 1, 4'd0,
                prrs_pkg::IDLE_ID, prrs_pkg::STS_BAD_ID);
        add_row(prrs_pkg::KIND_KILL, 16'd5, 8'd0, 32'd0, 1, 4'd0,
                prrs_pkg::IDLE_ID, prrs_pkg::STS_NOTFOUND);
        add_row(prrs_pkg::KIND_BLOCK, prrs_pkg::IDLE_ID, 8'd0, 32'd0, 1, 4'd0,
                prrs_pkg::IDLE_ID, prrs_pkg::STS_BAD_ID);
        add_row(prrs_pkg::KIND_UNBLOCK, 16'd9, 8'd0, 32'd0, 1, 4'd0,
                prrs_pkg::IDLE_ID, prrs_pkg::STS_NOTFOUND);
        add_row(prrs_pkg::KIND_ADD, prrs_pkg::IDLE_ID, 8'd3, 32'd0, 1, 4'd0,
                prrs_pkg::IDLE_ID, prrs_pkg::STS_BAD_ID);
        add_row(KIND_SPARE, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 1, 4'd0,
                prrs_pkg::IDLE_ID, prrs_pkg::STS_OK);
        // fill the ring: priorities 255, 0 and 7, duplicate ids
        add_row(prrs_pkg::KIND_ADD, 16'd1, 8'd255, 32'd0);
        add_row(prrs_pkg::KIND_ADD, 16'd2, 8'd0,   32'd0);
        for (int i = 3; i <= 15; i++)
            add_row(prrs_pkg::KIND_ADD, (i == 15) ? 16'd2 : 16'(i), 8'd7, 32'd0);
        add_row(prrs_pkg::KIND_ADD, 16'hFFFE, 8'd1, 32'd0, 1, 4'd0,
                prrs_pkg::IDLE_ID, prrs_pkg::STS_FULL);
        add_row(prrs_pkg::KIND_TICK,    16'd0, 8'd0, 32'd0);
        add_row(prrs_pkg::KIND_SLEEP,   16'd0, 8'd0, 32'd2);
        add_row(prrs_pkg::KIND_BLOCK,   16'd2, 8'd0, 32'd0);
        add_row(prrs_pkg::KIND_TICK,    16'd0, 8'd0, 32'd0);
        add_row(prrs_pkg::KIND_TICK,    16'd0, 8'd0, 32'd0);
        add_row(prrs_pkg::KIND_UNBLOCK, 16'd2, 8'd0, 32'd0);
        add_row(prrs_pkg::KIND_KILL,    16'd2, 8'd0, 32'd0);
        add_row(prrs_pkg::KIND_SLEEP,   16'd0, 8'd0, 32'hFFFFFFFF);

        phase_pct = '{'{0, 0}, '{45, 0}, '{0, 45}, '{31, 31}};
        sched_reset();

        // hold reset, then release
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_request(directed_rows[k].r, directed_rows[k].typed,
                         directed_rows[k].slot, directed_rows[k].id, directed_rows[k].sts);

        // random part, split over the idle/stall phases
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = phase_pct[ph][0];
            recv_stall_pct = phase_pct[ph][1];
            for (int n = 0; n < 270; n++) send_request(random_request());
        end
        go_quiet();
        send_idle_pct = 0;

        // drain, then allow the block's latency before the verdict
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb_priority_round_robin_thread_scheduler: done, clean");
        else
            $display("tb_priority_round_robin_thread_scheduler: done, errors");
        $finish;
    end

    // watchdog: ~1100 requests, some under heavy stall
    initial begin
        #5ms;
        $display("tb_priority_round_robin_thread_scheduler: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
sv/prrs_pkg.sv
sv/prrs_ctrl.sv
sv/prrs_dpath.sv
sv/priority_round_robin_thread_scheduler.sv
tb/tb_priority_round_robin_thread_scheduler.sv
